/* src/lmmw_pkg.sv */
package lmmw_pkg;

	// Field and register widths
	localparam int PIX_W     = 16;
	localparam int DIM_W     = 11;
	localparam int PEAK_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int WEIGHT_W  = 18;
	localparam int COUNT_W   = 19;
	localparam int SUM_W     = 35;

	// Weight arithmetic widths
	localparam int FRAC_W = 16;
	localparam int PROD_W = PEAK_W + COUNT_W;
	localparam int REM_W  = PROD_W + 1;
	localparam int QUO_W  = FRAC_W + 1;

	// Default frame limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_VALUE   = 2'd2;

	// Register reset values
	localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 11'd480;
	localparam logic [PEAK_W-1:0] PEAK_VALUE_RST   = 16'd65280;

	localparam logic [COUNT_W-1:0]  TALLY_MAX  = 19'd524287;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 18'd262143;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 18'd65536;

	typedef logic [PIX_W-1:0] pixel_t;

	// Top level to weight unit
	typedef struct packed {
		logic start;
		logic take;
	} wu_ctl_t;

	// Weight unit to top level
	typedef struct packed {
		logic busy;
		logic done;
	} wu_sts_t;

endpackage

/* src/lmmw_ram.sv */
module lmmw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/lmmw_weight.sv */
module lmmw_weight (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lmmw_pkg::wu_ctl_t               ctl,
	output lmmw_pkg::wu_sts_t               sts,
	input  logic [lmmw_pkg::SUM_W-1:0]      sum_in,
	input  logic [lmmw_pkg::COUNT_W-1:0]    tally_in,
	input  logic [lmmw_pkg::PEAK_W-1:0]     peak_in,
	output logic [lmmw_pkg::WEIGHT_W-1:0]   weight,
	output logic [lmmw_pkg::COUNT_W-1:0]    count
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIFF = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_SQR  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam int CNT_W = $clog2(lmmw_pkg::QUO_W);

	logic [2:0]                      state_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [lmmw_pkg::SUM_W-1:0]      sum_q;
	logic [lmmw_pkg::COUNT_W-1:0]    n_q;
	logic [lmmw_pkg::PEAK_W-1:0]     p_q;
	logic [lmmw_pkg::PROD_W-1:0]     pn_q;
	logic [lmmw_pkg::PROD_W-1:0]     div_q;
	logic [lmmw_pkg::REM_W-1:0]      rem_q;
	logic [lmmw_pkg::QUO_W-1:0]      quo_q;
	logic [lmmw_pkg::WEIGHT_W-1:0]   weight_q;
	logic [2*lmmw_pkg::QUO_W-1:0]    sq;
	logic                            sat;
	logic                            rem_ge;

	// The ratio reaches two or more: the squared weight would not fit.
	assign sat    = rem_q >= {div_q, 1'b0};
	assign rem_ge = rem_q >= lmmw_pkg::REM_W'(div_q);
	assign sq     = quo_q * quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						if (tally_in inside {lmmw_pkg::COUNT_W'(0), lmmw_pkg::COUNT_W'(1)}) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_CHK;
				ST_CHK: begin
					cnt_q <= '0;
					state_q <= sat ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(lmmw_pkg::QUO_W - 1)) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR:  state_q <= ST_DONE;
				ST_DONE: begin
					if (ctl.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					sum_q <= sum_in;
					n_q   <= tally_in;
					p_q   <= peak_in;
					if (tally_in == lmmw_pkg::COUNT_W'(1)) begin
						weight_q <= lmmw_pkg::WEIGHT_ONE;
					end else begin
						weight_q <= '0;
					end
				end
			end
			ST_MUL: begin
				pn_q <= p_q * n_q;
			end
			ST_DIFF: begin
				if (pn_q >= lmmw_pkg::PROD_W'(sum_q)) begin
					rem_q <= lmmw_pkg::REM_W'(pn_q - lmmw_pkg::PROD_W'(sum_q));
				end else begin
					rem_q <= lmmw_pkg::REM_W'(lmmw_pkg::PROD_W'(sum_q) - pn_q);
				end
				// P*(n-1) is P*n less one P.
				div_q <= pn_q - lmmw_pkg::PROD_W'(p_q);
				quo_q <= '0;
			end
			ST_CHK: begin
				if (sat) begin
					weight_q <= lmmw_pkg::WEIGHT_MAX;
				end
			end
			ST_DIV: begin
				if (rem_ge) begin
					rem_q <= (rem_q - lmmw_pkg::REM_W'(div_q)) << 1;
					quo_q <= {quo_q[lmmw_pkg::QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_q << 1;
					quo_q <= {quo_q[lmmw_pkg::QUO_W-2:0], 1'b0};
				end
			end
			ST_SQR: begin
				weight_q <= sq[lmmw_pkg::FRAC_W +: lmmw_pkg::WEIGHT_W];
			end
			default: ;
		endcase
	end

	assign sts.busy = state_q != ST_IDLE;
	assign sts.done = state_q == ST_DONE;
	assign weight   = weight_q;
	assign count    = n_q;

endmodule

/* src/local_maxima_map_weight.sv */
// Result: one per frame, formed after the transfer of the frame's last pixel; the weight unit
// skips its division when the frame holds fewer than two maxima or the weight saturates.
// Throughput: one pixel per cycle inside a frame, set by the single line memory port pair;
// input stalls from the last pixel until the weight unit's result enters the output register.
// Reset: registers take their default values and the line memory is cleared by a pass that
// writes one entry per cycle, during which no pixel is accepted.
module local_maxima_map_weight #(
	parameter int MAX_WIDTH  = lmmw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lmmw_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lmmw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lmmw_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lmmw_pkg::PIX_W-1:0]        pixel,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lmmw_pkg::WEIGHT_W-1:0]     weight,
	output logic [lmmw_pkg::COUNT_W-1:0]      maxima_count
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// Configuration registers.
	logic [lmmw_pkg::DIM_W-1:0]  frame_width_q;
	logic [lmmw_pkg::DIM_W-1:0]  frame_height_q;
	logic [lmmw_pkg::PEAK_W-1:0] peak_q;
	logic [lmmw_pkg::PEAK_W-1:0] peak_eff;

	// Raster position of the next pixel and the last column and row of the frame.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_last;
	logic [RW-1:0] row_last;
	logic          row_end;
	logic          frame_end;
	logic          in_acc;

	// Line memory clearing pass.
	logic          clr_busy_q;
	logic [CW-1:0] clr_addr_q;

	// Pipeline: stage 1 has the line memory data, stage 2 the shifted window.
	logic                valid_s1;
	lmmw_pkg::pixel_t    pix_s1;
	logic [CW-1:0]       addr_s1;
	logic                test_s1;
	logic                eof_s1;
	logic                valid_s2;
	logic                test_s2;
	logic                eof_s2;

	logic                          ram_we;
	logic [CW-1:0]                 ram_waddr;
	logic [2*lmmw_pkg::PIX_W-1:0]  ram_wdata;
	logic [2*lmmw_pkg::PIX_W-1:0]  ram_rdata;
	lmmw_pkg::pixel_t              above1;
	lmmw_pkg::pixel_t              above2;

	lmmw_pkg::pixel_t win_q [3][3];
	logic             peak;

	logic [lmmw_pkg::SUM_W-1:0]   sum_q;
	logic [lmmw_pkg::SUM_W-1:0]   sum_nx;
	logic [lmmw_pkg::COUNT_W-1:0] tally_q;
	logic [lmmw_pkg::COUNT_W-1:0] tally_nx;
	logic                         add_max;

	lmmw_pkg::wu_ctl_t              wu_ctl;
	lmmw_pkg::wu_sts_t              wu_sts;
	logic [lmmw_pkg::WEIGHT_W-1:0]  wu_weight;
	logic [lmmw_pkg::COUNT_W-1:0]   wu_count;

	logic                          out_valid_q;
	logic [lmmw_pkg::WEIGHT_W-1:0] weight_q;
	logic [lmmw_pkg::COUNT_W-1:0]  count_q;
	logic                          out_free;

	// Configuration writes land at once; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= lmmw_pkg::FRAME_WIDTH_RST;
			frame_height_q <= lmmw_pkg::FRAME_HEIGHT_RST;
			peak_q         <= lmmw_pkg::PEAK_VALUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lmmw_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[lmmw_pkg::DIM_W-1:0];
				lmmw_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[lmmw_pkg::DIM_W-1:0];
				lmmw_pkg::REG_PEAK_VALUE:   peak_q         <= cfg_data[lmmw_pkg::PEAK_W-1:0];
				default: ;
			endcase
		end
	end

	// Frame sizes below three act as three and sizes above the maximum act as the maximum.
	// A peak of zero acts as one so the divisor can never vanish.
	always_comb begin
		if (frame_width_q < lmmw_pkg::DIM_W'(3)) begin
			col_last = CW'(2);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			col_last = CW'(MAX_WIDTH - 1);
		end else begin
			col_last = CW'(frame_width_q - lmmw_pkg::DIM_W'(1));
		end
		if (frame_height_q < lmmw_pkg::DIM_W'(3)) begin
			row_last = RW'(2);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			row_last = RW'(MAX_HEIGHT - 1);
		end else begin
			row_last = RW'(frame_height_q - lmmw_pkg::DIM_W'(1));
		end
	end

	assign peak_eff = (peak_q == '0) ? lmmw_pkg::PEAK_W'(1) : peak_q;

	// A row ends at or beyond the last column, so a narrower frame written between frames
	// still wraps cleanly.
	assign row_end   = col_q >= col_last;
	assign frame_end = row_end && (row_q >= row_last);

	// Input is held off during the clearing pass and from the transfer of a frame's last
	// pixel until the weight unit has handed its result to the output register.
	assign in_stall = clr_busy_q || (valid_s1 && eof_s1) || (valid_s2 && eof_s2) || wu_sts.busy;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// The clearing pass writes zero to every line memory entry once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CW'(1);
			if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pixel;
			addr_s1 <= col_q;
			test_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			eof_s1  <= frame_end;
		end
		test_s2 <= test_s1;
		eof_s2  <= eof_s1;
	end

	// One line memory entry per column holds the two rows above: the upper half is the
	// older row, the lower half the previous row. The read address is the current column,
	// so the data for a pixel arrives in the cycle after its transfer. Write-back happens in
	// stage 1 and the next pixel always reads a different column, so a read and a write of
	// the same entry never meet.
	assign above2    = ram_rdata[2*lmmw_pkg::PIX_W-1:lmmw_pkg::PIX_W];
	assign above1    = ram_rdata[lmmw_pkg::PIX_W-1:0];
	assign ram_we    = clr_busy_q || valid_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : {above1, pix_s1};

	lmmw_ram #(
		.WIDTH(2 * lmmw_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// The 3x3 window shifts left by one column for every pixel; the new right-hand column
	// is the two stored rows and the incoming pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= above2;
			win_q[1][2] <= above1;
			win_q[2][2] <= pix_s1;
		end
	end

	// The centre must be strictly greater than all eight neighbours.
	always_comb begin
		peak = 1'b1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!(i == 1 && j == 1) && !(win_q[1][1] > win_q[i][j])) begin
					peak = 1'b0;
				end
			end
		end
	end

	// Once the tally saturates, further maxima are neither counted nor summed.
	assign add_max  = valid_s2 && test_s2 && peak && (tally_q != lmmw_pkg::TALLY_MAX);
	assign sum_nx   = add_max ? sum_q + lmmw_pkg::SUM_W'(win_q[1][1]) : sum_q;
	assign tally_nx = add_max ? tally_q + lmmw_pkg::COUNT_W'(1) : tally_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			tally_q <= '0;
		end else if (valid_s2 && eof_s2) begin
			sum_q   <= '0;
			tally_q <= '0;
		end else begin
			sum_q   <= sum_nx;
			tally_q <= tally_nx;
		end
	end

	// The frame's totals, including its last pixel, go to the weight unit, which holds its
	// result until the output register can take it.
	assign out_free     = !out_valid_q || !out_stall;
	assign wu_ctl.start = valid_s2 && eof_s2;
	assign wu_ctl.take  = wu_sts.done && out_free;

	lmmw_weight u_weight (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (wu_ctl),
		.sts     (wu_sts),
		.sum_in  (sum_nx),
		.tally_in(tally_nx),
		.peak_in (peak_eff),
		.weight  (wu_weight),
		.count   (wu_count)
	);

	// Output register: a finished result waits here while the next frame streams in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wu_ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wu_ctl.take) begin
			weight_q <= wu_weight;
			count_q  <= wu_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign weight       = weight_q;
	assign maxima_count = count_q;

`ifndef SYNTHESIS
	// The weight unit is never restarted while it still holds a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		wu_ctl.start |-> !wu_sts.busy)
		else $error("weight unit started while busy");

	// Only one frame end is ever in the pixel pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && eof_s1 && valid_s2 && eof_s2))
		else $error("two frame ends in the pipeline");

	// The clearing pass runs once after reset and never again.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(clr_busy_q))
		else $error("clearing pass restarted");

	// A new frame starts its totals from zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		wu_ctl.start |=> (sum_q == '0 && tally_q == '0))
		else $error("frame totals not cleared at frame end");
`endif

endmodule

/* sim/tb.sv */
module tb;

	// Line store depth and height limit of the block as built with its default parameters.
	localparam int MAX_W = lmmw_pkg::MAX_WIDTH_DEF;
	localparam int MAX_H = lmmw_pkg::MAX_HEIGHT_DEF;

	// Index 3 has no register behind it; writes to it must leave every setting alone.
	localparam logic [lmmw_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// How the pixels of one frame are made up.
	typedef enum logic [2:0] {
		SH_FLAT,    // every pixel equal to the frame base
		SH_SPIKE,   // zeros with one full-scale pixel at the first interior site
		SH_PAIR,    // zeros with two separated maxima in the middle row
		SH_WIDE,    // uniform over the whole 16-bit range
		SH_NARROW,  // base plus 0..3, so ties between neighbours are common
		SH_SPARSE   // flat base with occasional random spikes
	} shape_t;

	typedef struct packed {
		logic [lmmw_pkg::WEIGHT_W-1:0] weight;
		logic [lmmw_pkg::COUNT_W-1:0]  count;
	} result_t;

	// One row of the directed plan: register values to write before the frame (negative
	// means leave alone), how the frame looks, and the result where it is obvious.
	typedef struct {
		int      w;
		int      h;
		int      p;
		int      junk;
		shape_t  shape;
		int      base;
		bit      typed;
		result_t exp;
	} plan_row_t;

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                cfg_we       = 1'b0;
	logic [lmmw_pkg::CFG_IDX_W-1:0]      cfg_index    = '0;
	logic [lmmw_pkg::CFG_W-1:0]          cfg_data     = '0;
	logic                                in_valid     = 1'b0;
	logic                                in_stall;
	logic [lmmw_pkg::PIX_W-1:0]          pixel        = '0;
	logic                                out_valid;
	logic                                out_stall    = 1'b0;
	logic [lmmw_pkg::WEIGHT_W-1:0]       weight;
	logic [lmmw_pkg::COUNT_W-1:0]        maxima_count;

	local_maxima_map_weight u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.weight       (weight),
		.maxima_count (maxima_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the block: its registers and its frame state. These move only when a
	// register write or a pixel transfer is seen at a rising edge.
	logic [lmmw_pkg::DIM_W-1:0]   cfg_width  = lmmw_pkg::FRAME_WIDTH_RST;
	logic [lmmw_pkg::DIM_W-1:0]   cfg_height = lmmw_pkg::FRAME_HEIGHT_RST;
	logic [lmmw_pkg::PEAK_W-1:0]  cfg_peak   = lmmw_pkg::PEAK_VALUE_RST;
	lmmw_pkg::pixel_t             rows_hist [2][MAX_W];  // [0] previous row, [1] the one before
	lmmw_pkg::pixel_t             win [3][3];
	int                           col_pos;
	int                           row_pos;
	logic [lmmw_pkg::SUM_W-1:0]   peak_sum;
	logic [lmmw_pkg::COUNT_W-1:0] peak_tally;

	// Weights predicted for frames already sent, oldest first.
	result_t weights_due [$];

	int      errors = 0;
	bit      calm = 1'b0;      // set for a stretch of frames with no idling on either side
	bit      typed_on = 1'b0;  // the current frame's result is taken from the directed plan
	result_t typed_res;
	shape_t  shape;
	int      base;

	// Widths and heights outside the supported range are pinned to the nearest end.
	function automatic int span_of(logic [lmmw_pkg::DIM_W-1:0] v, int hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	// Weight of a frame from the sum and count of its maxima and the peak value. The ratio
	// |P*n - S| / (P*(n-1)) is formed in Q1.16 and then squared; at a ratio of two or more
	// the square no longer fits, so the weight saturates.
	function automatic logic [lmmw_pkg::WEIGHT_W-1:0] weight_of(
			logic [lmmw_pkg::SUM_W-1:0] s, logic [lmmw_pkg::COUNT_W-1:0] n,
			logic [lmmw_pkg::PEAK_W-1:0] p);
		logic [63:0] pn;
		logic [63:0] d;
		logic [63:0] q;
		logic [63:0] ratio;
		if (n == 0)
			return '0;
		if (n == 1)
			return lmmw_pkg::WEIGHT_ONE;
		pn = 64'(p) * 64'(n);
		d = (pn >= 64'(s)) ? pn - 64'(s) : 64'(s) - pn;
		q = 64'(p) * (64'(n) - 64'd1);
		if (d >= 2 * q)
			return lmmw_pkg::WEIGHT_MAX;
		ratio = (d << 16) / q;
		return lmmw_pkg::WEIGHT_W'((ratio * ratio) >> 16);
	endfunction

	// Advance the shadow state by one accepted pixel. The window slides left, the new column
	// is filled from the two stored rows and the new pixel, and once two rows and two columns
	// have gone by, the centre of the window is tested against all eight neighbours.
	task automatic predict_pixel(input lmmw_pkg::pixel_t v, output bit got,
			output result_t res);
		int               w;
		int               h;
		int               idx;
		int               i;
		int               j;
		lmmw_pkg::pixel_t ctr;
		bit               top;
		w = span_of(cfg_width, MAX_W);
		h = span_of(cfg_height, MAX_H);
		idx = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
		got = 1'b0;
		res = '0;
		for (i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = rows_hist[1][idx];
		win[1][2] = rows_hist[0][idx];
		win[2][2] = v;
		rows_hist[1][idx] = rows_hist[0][idx];
		rows_hist[0][idx] = v;
		if (row_pos >= 2 && col_pos >= 2) begin
			ctr = win[1][1];
			top = 1'b1;
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++)
					if ((i != 1 || j != 1) && !(ctr > win[i][j]))
						top = 1'b0;
			// Once the tally is full, further maxima are neither counted nor summed.
			if (top && peak_tally < lmmw_pkg::TALLY_MAX) begin
				peak_sum = peak_sum + lmmw_pkg::SUM_W'(ctr);
				peak_tally = peak_tally + 1'b1;
			end
		end
		if (col_pos >= w - 1) begin
			col_pos = 0;
			if (row_pos >= h - 1) begin
				// End of frame: one result, and the sums start again from zero.
				got = 1'b1;
				res.weight = weight_of(peak_sum, peak_tally,
					(cfg_peak == 0) ? lmmw_pkg::PEAK_W'(1) : cfg_peak);
				res.count = peak_tally;
				row_pos = 0;
				peak_sum = '0;
				peak_tally = '0;
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	function automatic lmmw_pkg::pixel_t clip16(int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return lmmw_pkg::PIX_W'(v);
	endfunction

	function automatic lmmw_pkg::pixel_t frame_pixel(int r, int c);
		case (shape)
			SH_FLAT:   return clip16(base);
			SH_SPIKE:  return (r == 1 && c == 1) ? 16'hFFFF : 16'h0000;
			SH_PAIR: begin
				if (r == 1 && c == 1)
					return 16'hFFFF;
				return (r == 1 && c == 3) ? 16'h0001 : 16'h0000;
			end
			SH_WIDE:   return lmmw_pkg::PIX_W'($urandom);
			SH_NARROW: return clip16(base + $urandom_range(3));
			default: begin
				if ($urandom_range(11) == 0)
					return lmmw_pkg::PIX_W'($urandom);
				return clip16(base);
			end
		endcase
	endfunction

	// Offer one pixel, possibly after a few idle cycles, and hold it until the block takes
	// it. The shadow state moves at the edge of the transfer.
	task automatic send_pixel(input lmmw_pkg::pixel_t v);
		bit      got;
		result_t res;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_pixel(v, got, res);
		if (got) begin
			if (typed_on)
				weights_due.push_back(typed_res);
			else
				weights_due.push_back(res);
		end
	endtask

	task automatic send_frame();
		int w;
		int h;
		int r;
		int c;
		w = span_of(cfg_width, MAX_W);
		h = span_of(cfg_height, MAX_H);
		for (r = 0; r < h; r++)
			for (c = 0; c < w; c++)
				send_pixel(frame_pixel(r, c));
	endtask

	// Stop sending and wait until every predicted weight has come out, then allow for the
	// block's end-of-frame latency before anything is changed.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (weights_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [lmmw_pkg::CFG_IDX_W-1:0] idx,
			logic [lmmw_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			lmmw_pkg::REG_FRAME_WIDTH:  cfg_width = data[lmmw_pkg::DIM_W-1:0];
			lmmw_pkg::REG_FRAME_HEIGHT: cfg_height = data[lmmw_pkg::DIM_W-1:0];
			lmmw_pkg::REG_PEAK_VALUE:   cfg_peak = data[lmmw_pkg::PEAK_W-1:0];
			default: ;
		endcase
	endtask

	// Register writes only happen once the block has gone quiet between frames.
	task automatic retune(int w, int h, int p, int junk);
		if (w < 0 && h < 0 && p < 0 && junk < 0)
			return;
		drain();
		if (w >= 0)
			write_reg(lmmw_pkg::REG_FRAME_WIDTH, lmmw_pkg::CFG_W'(w));
		if (h >= 0)
			write_reg(lmmw_pkg::REG_FRAME_HEIGHT, lmmw_pkg::CFG_W'(h));
		if (p >= 0)
			write_reg(lmmw_pkg::REG_PEAK_VALUE, lmmw_pkg::CFG_W'(p));
		if (junk >= 0)
			write_reg(REG_SPARE, lmmw_pkg::CFG_W'(junk));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly small sizes, now and then one below the range or one with high bits that the
	// register does not keep.
	function automatic int pick_dim(int hi);
		int roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return $urandom_range(hi, 3);
		if (roll < 92)
			return $urandom_range(2, 0);
		return ($urandom_range(31, 1) << 11) | $urandom_range(hi, 3);
	endfunction

	function automatic int pick_peak();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return $urandom_range(65535);
		if (roll < 55)
			return 0;
		if (roll < 70)
			return 65535;
		if (roll < 80)
			return 1;
		return $urandom_range(1023, 1);
	endfunction

	// The receiver holds off results at random, except during the calm stretch.
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 21);

	// Every result transfer is matched against the oldest predicted weight.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (weights_due.size() == 0) begin
				$error("result with nothing pending: weight %0d, maxima_count %0d",
					weight, maxima_count);
				errors++;
			end else begin
				if (weight !== weights_due[0].weight) begin
					$error("weight: expected %0d, got %0d", weights_due[0].weight, weight);
					errors++;
				end
				if (maxima_count !== weights_due[0].count) begin
					$error("maxima_count: expected %0d, got %0d",
						weights_due[0].count, maxima_count);
					errors++;
				end
				void'(weights_due.pop_front());
			end
		end
	end

	// This timeout lies well beyond the length of a correct run.
	initial begin
		#3000000;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		plan_row_t plan [3];
		int        i;
		int        j;
		int        frame_no;
		int        pixels;
		int        w_val;
		int        h_val;
		int        p_val;
		int        junk;
		int        roll;

		for (i = 0; i < MAX_W; i++) begin
			rows_hist[0][i] = '0;
			rows_hist[1][i] = '0;
		end
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++)
				win[i][j] = '0;
		col_pos = 0;
		row_pos = 0;
		peak_sum = '0;
		peak_tally = '0;
		pixels = 0;

		// Directed frames. A width of 0 and a height of 2 both act as 3, so the first frame
		// is 3x3 under the default peak: flat, hence no maxima and a zero weight. The second
		// has a lone spike, which gives a weight of exactly one; the write to the spare index
		// before it must change nothing. The third has two separated maxima under a zero
		// peak, which acts as 1, and so saturates.
		plan[0] = '{w: 0, h: 2, p: -1, junk: -1, shape: SH_FLAT, base: 65535,
			typed: 1'b1, exp: '0};
		plan[1] = '{w: -1, h: -1, p: -1, junk: 65535, shape: SH_SPIKE, base: 0,
			typed: 1'b1, exp: '{weight: lmmw_pkg::WEIGHT_ONE, count: 19'd1}};
		plan[2] = '{w: 5, h: 3, p: 0, junk: -1, shape: SH_PAIR, base: 0,
			typed: 1'b1, exp: '{weight: lmmw_pkg::WEIGHT_MAX, count: 19'd2}};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < 3; i++) begin
			retune(plan[i].w, plan[i].h, plan[i].p, plan[i].junk);
			shape = plan[i].shape;
			base = plan[i].base;
			typed_on = plan[i].typed;
			typed_res = plan[i].exp;
			send_frame();
			pixels += span_of(cfg_width, MAX_W) * span_of(cfg_height, MAX_H);
			typed_on = 1'b0;
		end

		// Random frames at small sizes. Between frames the registers are changed now and
		// then; otherwise frames follow each other with no pause.
		frame_no = 0;
		while (pixels < 1760 || frame_no < 24) begin
			w_val = -1;
			h_val = -1;
			p_val = -1;
			junk = -1;
			if ($urandom_range(99) < 40) begin
				if ($urandom_range(1))
					w_val = pick_dim(10);
				if ($urandom_range(1))
					h_val = pick_dim(8);
				if ($urandom_range(1))
					p_val = pick_peak();
				if ($urandom_range(9) == 0)
					junk = $urandom_range(65535);
			end
			retune(w_val, h_val, p_val, junk);

			roll = $urandom_range(99);
			if (roll < 30)
				shape = SH_WIDE;
			else if (roll < 65)
				shape = SH_NARROW;
			else if (roll < 95)
				shape = SH_SPARSE;
			else
				shape = SH_FLAT;
			// Keeping the base near the peak puts the mean of the maxima close to it, which
			// is where the weight takes values between zero and saturation.
			if ($urandom_range(1))
				base = int'((cfg_peak == 0) ? 1 : cfg_peak) - $urandom_range(4);
			else
				base = $urandom_range(65535);

			calm = (frame_no >= 15 && frame_no < 23);
			send_frame();
			pixels += span_of(cfg_width, MAX_W) * span_of(cfg_height, MAX_H);
			frame_no++;
		end
		calm = 1'b0;

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

/* local_maxima_map_weight.f */
src/lmmw_pkg.sv
src/lmmw_ram.sv
src/lmmw_weight.sv
src/local_maxima_map_weight.sv
sim/tb.sv
